### rtl/palette_pixel_art_upscaler_defines.svh
// assertion macros for the upscaler rtl
`ifndef PALETTE_PIXEL_ART_UPSCALER_DEFINES_SVH
`define PALETTE_PIXEL_ART_UPSCALER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define PUA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");
// next-cycle implication, disabled in reset
`define PUA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");
`else
`define PUA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PUA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/pua_pkg.sv
// types, constants and codes for the palette pixel-art upscaler
package pua_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int COLOR_BITS      = 16;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IDX_W           = 8;
  localparam int PIX_W           = 16;
  localparam int WIN_N           = 9;

  // window positions, row major, center is E
  localparam int WIN_A = 0;
  localparam int WIN_B = 1;
  localparam int WIN_C = 2;
  localparam int WIN_D = 3;
  localparam int WIN_E = 4;
  localparam int WIN_F = 5;
  localparam int WIN_G = 6;
  localparam int WIN_H = 7;
  localparam int WIN_I = 8;

  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  localparam logic CFG_SCALE_MODE    = 1'b0;
  localparam logic CFG_SMOOTH_FACTOR = 1'b1;

  localparam logic [1:0] FACTOR_SCALE3X = 2'd3;
  localparam logic [1:0] FACTOR_RESET   = 2'd2;

  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [IDX_W-1:0]      pidx_t;
  typedef logic [PIX_W-1:0]      pix_t;

  typedef enum logic [1:0] {
    MODE_POINT1 = 2'd0,
    MODE_POINT2 = 2'd1,
    MODE_POINT3 = 2'd2,
    MODE_SMOOTH = 2'd3
  } mode_t;

  typedef struct packed {
    logic  load;
    mode_t mode;
    logic  scale3x;
  } mrg_ctrl_t;

  function automatic logic idx_in_range(input pidx_t idx);
    idx_in_range = ({1'b0, idx} < (IDX_W + 1)'(PALETTE_ENTRIES));
  endfunction

endpackage

### rtl/palette_pixel_art_upscaler.sv
// top level: nine palette lookup lanes feeding a scale-rule merge stage
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    op, 3x3 window indices, entry_color
//   out_     output     out_valid / out_ready  px_r0_c0 .. px_r2_c2
//   cfg_     input      cfg_we                 cfg_idx, cfg_data
//
// one item per cycle sustained while out_ready is high; a pixel item passes the lane palette
// read register, then the merge register, to reach the output; palette writes give no result
// each lane keeps its own palette copy so all nine lookups happen in the same cycle
// reset clears the pipeline valids and presets the mode registers; palette is undefined until written
// a stalled output holds its block; in_ready follows out_ready through the two stages

`include "palette_pixel_art_upscaler_defines.svh"

module palette_pixel_art_upscaler import pua_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  pidx_t      in_up_left,
  input  pidx_t      in_up,
  input  pidx_t      in_up_right,
  input  pidx_t      in_left,
  input  pidx_t      in_center,
  input  pidx_t      in_right,
  input  pidx_t      in_down_left,
  input  pidx_t      in_down,
  input  pidx_t      in_down_right,
  input  logic [15:0] in_entry_color,

  output logic       out_valid,
  input  logic       out_ready,
  output pix_t       out_px_r0_c0,
  output pix_t       out_px_r0_c1,
  output pix_t       out_px_r0_c2,
  output pix_t       out_px_r1_c0,
  output pix_t       out_px_r1_c1,
  output pix_t       out_px_r1_c2,
  output pix_t       out_px_r2_c0,
  output pix_t       out_px_r2_c1,
  output pix_t       out_px_r2_c2,

  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [1:0] cfg_data
);

  mode_t      scale_mode_r;
  logic [1:0] smooth_factor_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, s1_load, in_accept, pix_accept, pal_accept;
  pidx_t      win_idx [WIN_N];
  color_t     win_color [WIN_N];
  color_t     wr_color;
  pix_t       blk [WIN_N];
  mrg_ctrl_t  mrg_ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r    <= MODE_POINT1;
      smooth_factor_r <= FACTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SCALE_MODE:    scale_mode_r    <= mode_t'(cfg_data);
        CFG_SMOOTH_FACTOR: smooth_factor_r <= cfg_data;
        default: begin
          smooth_factor_r <= smooth_factor_r;
        end
      endcase
    end
  end

  // handshake chain: output register, then lane read register
  assign out_free   = !out_valid_r || out_ready;
  assign s1_load    = s1_valid_r && out_free;
  assign in_ready   = !s1_valid_r || out_free;
  assign in_accept  = in_valid && in_ready;
  assign pix_accept = in_accept && (in_op == OP_PIXEL);
  assign pal_accept = in_accept && (in_op == OP_PALETTE);

  assign s1_valid_nxt  = pix_accept || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_valid_r || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign win_idx[WIN_A] = in_up_left;
  assign win_idx[WIN_B] = in_up;
  assign win_idx[WIN_C] = in_up_right;
  assign win_idx[WIN_D] = in_left;
  assign win_idx[WIN_E] = in_center;
  assign win_idx[WIN_F] = in_right;
  assign win_idx[WIN_G] = in_down_left;
  assign win_idx[WIN_H] = in_down;
  assign win_idx[WIN_I] = in_down_right;

  assign wr_color = COLOR_BITS'(in_entry_color);

  for (genvar g = 0; g < WIN_N; g++) begin : g_lane
    pua_lane u_lane (
      .clk      (clk),
      .wr_en    (pal_accept),
      .wr_idx   (in_center),
      .wr_color (wr_color),
      .rd_en    (pix_accept),
      .rd_idx   (win_idx[g]),
      .rd_color (win_color[g])
    );
  end

  assign mrg_ctrl.load    = s1_load;
  assign mrg_ctrl.mode    = scale_mode_r;
  assign mrg_ctrl.scale3x = (smooth_factor_r == FACTOR_SCALE3X);

  pua_merge u_merge (
    .clk   (clk),
    .ctrl  (mrg_ctrl),
    .win   (win_color),
    .blk_r (blk)
  );

  assign out_valid    = out_valid_r;
  assign out_px_r0_c0 = blk[0];
  assign out_px_r0_c1 = blk[1];
  assign out_px_r0_c2 = blk[2];
  assign out_px_r1_c0 = blk[3];
  assign out_px_r1_c1 = blk[4];
  assign out_px_r1_c2 = blk[5];
  assign out_px_r2_c0 = blk[6];
  assign out_px_r2_c1 = blk[7];
  assign out_px_r2_c2 = blk[8];

  // a pixel item always lands in the lane stage
  `PUA_ASSERT_NEXT(a_pix_enters_s1, clk, rst_n, pix_accept, s1_valid_r)
  // a palette write never leaves a pending lane read behind
  `PUA_ASSERT_NEXT(a_pal_no_result, clk, rst_n, pal_accept, !s1_valid_r)
  // lane data moves on whenever the output stage is empty
  `PUA_ASSERT_NEXT(a_s1_drains, clk, rst_n, s1_valid_r && !out_valid_r, out_valid_r)
  // input is blocked only when both stages hold items
  `PUA_ASSERT_SAME(a_ready_rule, clk, rst_n, !in_ready, s1_valid_r && out_valid_r)

endmodule

### rtl/pua_lane.sv
// one lookup lane: a private palette copy with a registered read port
module pua_lane import pua_pkg::*; (
  input  logic   clk,
  input  logic   wr_en,
  input  pidx_t  wr_idx,
  input  color_t wr_color,
  input  logic   rd_en,
  input  pidx_t  rd_idx,
  output color_t rd_color
);

  color_t mem [PALETTE_ENTRIES];
  color_t data_r;
  logic   oob_r;

  // every lane sees every palette write so all copies agree
  always_ff @(posedge clk) begin
    if (wr_en && idx_in_range(wr_idx)) begin
      mem[wr_idx[PAL_AW-1:0]] <= wr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= mem[rd_idx[PAL_AW-1:0]];
      oob_r  <= !idx_in_range(rd_idx);
    end
  end

  // index past the palette reads as color zero
  assign rd_color = oob_r ? '0 : data_r;

endmodule

### rtl/pua_merge.sv
// merge stage: applies the point or smooth rule to the nine lane colors
module pua_merge import pua_pkg::*; (
  input  logic      clk,
  input  mrg_ctrl_t ctrl,
  input  color_t    win [WIN_N],
  output pix_t      blk_r [WIN_N]
);

  color_t blk [WIN_N];
  color_t ca, cb, cc, cd, ce, cf, cg, ch, ci;
  logic   flat;

  assign ca = win[WIN_A];
  assign cb = win[WIN_B];
  assign cc = win[WIN_C];
  assign cd = win[WIN_D];
  assign ce = win[WIN_E];
  assign cf = win[WIN_F];
  assign cg = win[WIN_G];
  assign ch = win[WIN_H];
  assign ci = win[WIN_I];

  // no edge through the center: block is plain E
  assign flat = (cb == ch) || (cd == cf);

  always_comb begin
    for (int j = 0; j < WIN_N; j++) begin
      blk[j] = '0;
    end
    case (ctrl.mode)
      MODE_POINT1: begin
        blk[0] = ce;
      end
      MODE_POINT2: begin
        blk[0] = ce;
        blk[1] = ce;
        blk[3] = ce;
        blk[4] = ce;
      end
      MODE_POINT3: begin
        for (int j = 0; j < WIN_N; j++) begin
          blk[j] = ce;
        end
      end
      MODE_SMOOTH: begin
        if (ctrl.scale3x) begin
          for (int j = 0; j < WIN_N; j++) begin
            blk[j] = ce;
          end
          if (!flat) begin
            blk[0] = (cd == cb) ? cd : ce;
            blk[1] = (((cd == cb) && (ce != cc)) || ((cb == cf) && (ce != ca))) ? cb : ce;
            blk[2] = (cb == cf) ? cf : ce;
            blk[3] = (((cd == cb) && (ce != cg)) || ((cd == ch) && (ce != ca))) ? cd : ce;
            blk[5] = (((cb == cf) && (ce != ci)) || ((ch == cf) && (ce != cc))) ? cf : ce;
            blk[6] = (cd == ch) ? cd : ce;
            blk[7] = (((cd == ch) && (ce != ci)) || ((ch == cf) && (ce != cg))) ? ch : ce;
            blk[8] = (ch == cf) ? cf : ce;
          end
        end else begin
          blk[0] = ce;
          blk[1] = ce;
          blk[3] = ce;
          blk[4] = ce;
          if (!flat) begin
            blk[0] = (cd == cb) ? cd : ce;
            blk[1] = (cb == cf) ? cf : ce;
            blk[3] = (cd == ch) ? cd : ce;
            blk[4] = (ch == cf) ? cf : ce;
          end
        end
      end
      default: begin
        blk[0] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int j = 0; j < WIN_N; j++) begin
        blk_r[j] <= PIX_W'(blk[j]);
      end
    end
  end

endmodule
